FILE: rtl/kbt_pkg.sv
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and codes of the XOR-distance k-bucket routing table.
// ----------------------------------------------------------------------------
package kbt_pkg;

   localparam int ACTION_W     = 2;
   localparam int STATUS_W     = 4;
   localparam int ID_PORT_W    = 64;
   localparam int EP_PORT_W    = 48;
   localparam int BIDX_PORT_W  = 6;
   localparam int REQ_DATA_W   = 120;
   localparam int RSP_DATA_W   = 120;

   localparam logic [ACTION_W-1:0] ACT_CONTACT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_VERDICT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      RS_ADDED      = 4'd0,
      RS_UPDATED    = 4'd1,
      RS_KNOWN      = 4'd2,
      RS_OWN_ID     = 4'd3,
      RS_PING       = 4'd4,
      RS_KEPT       = 4'd5,
      RS_REPLACED   = 4'd6,
      RS_FOUND      = 4'd7,
      RS_NOT_FOUND  = 4'd8,
      RS_BUSY       = 4'd9,
      RS_NO_PENDING = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                alive;
      logic                own_hit;
      logic                no_pending;
      logic                pend_valid;
   } op_type;

   typedef struct packed {
      status_type             status;
      logic [ID_PORT_W-1:0]   result_id;
      logic [EP_PORT_W-1:0]   result_endpoint;
      logic [BIDX_PORT_W-1:0] bucket_index;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic pend_set;
   } ctl_type;

endpackage

FILE: rtl/kbt_ram.sv
// ----------------------------------------------------------------------------
// kbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/kbt_bucket_update.sv
// ----------------------------------------------------------------------------
// kbt_bucket_update
// Decides one item against one bucket row and builds the row to write back.
// ----------------------------------------------------------------------------
module kbt_bucket_update #(
   parameter int ID_BITS       = 64,
   parameter int BUCKET_SLOTS  = 4,
   parameter int ENDPOINT_BITS = 48,
   localparam int EP_W   = (ENDPOINT_BITS < 48) ? ENDPOINT_BITS : 48,
   localparam int RANK_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1,
   localparam int FILL_W = $clog2(BUCKET_SLOTS + 1),
   localparam int SLOT_W = ID_BITS + EP_W + RANK_W,
   localparam int ROW_W  = BUCKET_SLOTS * SLOT_W + FILL_W,
   localparam int BIDX_W = $clog2(ID_BITS)
) (
   input  kbt_pkg::op_type    op,
   input  logic [ID_BITS-1:0] peer_id,
   input  logic [EP_W-1:0]    peer_ep,
   input  logic [BIDX_W-1:0]  bucket,
   input  logic               row_valid,
   input  logic [ROW_W-1:0]   row_rd,
   output logic [ROW_W-1:0]   row_wr,
   output kbt_pkg::rsp_type   rsp,
   output kbt_pkg::ctl_type   ctl
);

   logic [ID_BITS-1:0] ids       [BUCKET_SLOTS];
   logic [EP_W-1:0]    eps       [BUCKET_SLOTS];
   logic [RANK_W-1:0]  ranks     [BUCKET_SLOTS];
   logic [ID_BITS-1:0] new_ids   [BUCKET_SLOTS];
   logic [EP_W-1:0]    new_eps   [BUCKET_SLOTS];
   logic [RANK_W-1:0]  new_ranks [BUCKET_SLOTS];
   logic [FILL_W-1:0]  fill;
   logic [FILL_W-1:0]  new_fill;
   logic [BUCKET_SLOTS-1:0] match;
   logic               hit;
   logic [RANK_W-1:0]  hslot;
   logic [RANK_W-1:0]  oslot;
   logic [RANK_W-1:0]  tslot;
   logic [RANK_W-1:0]  old_rank;
   logic               newest;

   always_comb begin
      fill = row_valid ? row_rd[BUCKET_SLOTS*SLOT_W +: FILL_W] : '0;
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
         ids[s]   = row_rd[s*SLOT_W +: ID_BITS];
         eps[s]   = row_rd[s*SLOT_W + ID_BITS +: EP_W];
         ranks[s] = row_rd[s*SLOT_W + ID_BITS + EP_W +: RANK_W];
         match[s] = (FILL_W'(s) < fill) && (ids[s] == peer_id);
      end
      hit   = |match;
      hslot = '0;
      oslot = '0;
      for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
         if (match[s]) begin
            hslot = RANK_W'(s);
         end
         if ((FILL_W'(s) < fill) && (ranks[s] == '0)) begin
            oslot = RANK_W'(s);
         end
      end
   end

   always_comb begin
      new_ids   = ids;
      new_eps   = eps;
      new_ranks = ranks;
      new_fill  = fill;
      tslot     = hslot;
      newest    = 1'b0;
      old_rank  = '0;
      ctl       = '0;
      rsp.status          = kbt_pkg::RS_ADDED;
      rsp.result_id       = '0;
      rsp.result_endpoint = '0;
      rsp.bucket_index    = kbt_pkg::BIDX_PORT_W'(bucket);

      if (op.no_pending) begin
         rsp.status       = kbt_pkg::RS_NO_PENDING;
         rsp.bucket_index = '0;
      end else if (op.own_hit) begin
         rsp.status       = kbt_pkg::RS_OWN_ID;
         rsp.bucket_index = '0;
      end else if (op.action[1]) begin
         if (hit) begin
            rsp.status          = kbt_pkg::RS_FOUND;
            rsp.result_id       = kbt_pkg::ID_PORT_W'(peer_id);
            rsp.result_endpoint = kbt_pkg::EP_PORT_W'(eps[hslot]);
         end else begin
            rsp.status = kbt_pkg::RS_NOT_FOUND;
         end
      end else if (hit) begin
         if ((op.action == kbt_pkg::ACT_CONTACT) && (eps[hslot] != peer_ep)) begin
            new_eps[hslot] = peer_ep;
            newest         = 1'b1;
            tslot          = hslot;
            ctl.wr_en      = 1'b1;
            rsp.status     = kbt_pkg::RS_UPDATED;
         end else begin
            rsp.status = kbt_pkg::RS_KNOWN;
         end
      end else if (fill < FILL_W'(BUCKET_SLOTS)) begin
         new_ids[RANK_W'(fill)]   = peer_id;
         new_eps[RANK_W'(fill)]   = peer_ep;
         new_ranks[RANK_W'(fill)] = RANK_W'(fill);
         new_fill                 = FILL_W'(fill + 1'b1);
         ctl.wr_en                = 1'b1;
         rsp.status               = kbt_pkg::RS_ADDED;
      end else begin
         rsp.result_id       = kbt_pkg::ID_PORT_W'(ids[oslot]);
         rsp.result_endpoint = kbt_pkg::EP_PORT_W'(eps[oslot]);
         if (op.action == kbt_pkg::ACT_CONTACT) begin
            if (op.pend_valid) begin
               rsp.status          = kbt_pkg::RS_BUSY;
               rsp.result_id       = '0;
               rsp.result_endpoint = '0;
            end else begin
               ctl.pend_set = 1'b1;
               rsp.status   = kbt_pkg::RS_PING;
            end
         end else if (op.alive) begin
            newest     = 1'b1;
            tslot      = oslot;
            ctl.wr_en  = 1'b1;
            rsp.status = kbt_pkg::RS_KEPT;
         end else begin
            new_ids[oslot] = peer_id;
            new_eps[oslot] = peer_ep;
            newest         = 1'b1;
            tslot          = oslot;
            ctl.wr_en      = 1'b1;
            rsp.status     = kbt_pkg::RS_REPLACED;
         end
      end

      if (newest) begin
         old_rank = ranks[tslot];
         for (int s = 0; s < BUCKET_SLOTS; s++) begin
            if ((FILL_W'(s) < fill) && (ranks[s] > old_rank)) begin
               new_ranks[s] = ranks[s] - 1'b1;
            end
         end
         new_ranks[tslot] = RANK_W'(fill - 1'b1);
      end
   end

   always_comb begin
      row_wr = '0;
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
         row_wr[s*SLOT_W +: SLOT_W] = {new_ranks[s], new_eps[s], new_ids[s]};
      end
      row_wr[BUCKET_SLOTS*SLOT_W +: FILL_W] = new_fill;
   end

endmodule

FILE: rtl/xor_distance_kbucket_table_core.sv
// ----------------------------------------------------------------------------
// xor_distance_kbucket_table_core
// Kademlia-style routing table: one memory row per XOR-distance bucket.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  write own_id; always ready, write only while the table is idle.
//   req_*  one beat per item: tuser carries the action, tdata the peer id,
//          endpoint and ping verdict.
//   rsp_*  one beat per item: tuser carries the status, tdata the result
//          id, endpoint and bucket index.
// The accept cycle computes the bucket and issues the row read; the
// decide state then checks the item against the registered row and writes
// it back. The next item is taken only once the block is back in idle, so
// items do not overlap, limited by the single read-modify-write of a
// bucket row.
// Reset clears the per-row valid bits and the pending peer at once; a row
// not yet written reads as an empty bucket, so no clearing pass is needed.
// While the receiver stalls, one finished beat waits in the output
// register; one more item may be accepted and holds in its decide cycle
// until the output register frees.
// ----------------------------------------------------------------------------
module xor_distance_kbucket_table_core #(
   parameter int ID_BITS       = 64,
   parameter int BUCKET_SLOTS  = 4,
   parameter int ENDPOINT_BITS = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kbt_pkg::ID_PORT_W-1:0]    csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // peer_id, peer_endpoint, oldest_alive
   input  logic [kbt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [kbt_pkg::ACTION_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_id, result_endpoint, bucket_index
   output logic [kbt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [kbt_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int EP_W   = (ENDPOINT_BITS < 48) ? ENDPOINT_BITS : 48;
   localparam int RANK_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
   localparam int SLOT_W = ID_BITS + EP_W + RANK_W;
   localparam int ROW_W  = BUCKET_SLOTS * SLOT_W + FILL_W;
   localparam int BIDX_W = $clog2(ID_BITS);
   localparam int EP_LSB = kbt_pkg::ID_PORT_W;
   localparam int AL_BIT = kbt_pkg::ID_PORT_W + kbt_pkg::EP_PORT_W;

   kbt_pkg::state_type state_ff, state_in;
   logic [ID_BITS-1:0] own_id_ff;
   logic               pend_valid_ff;
   logic [ID_BITS-1:0] pend_id_ff;
   logic [EP_W-1:0]    pend_ep_ff;
   kbt_pkg::op_type    op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [EP_W-1:0]    ep_ff, ep_in;
   logic [BIDX_W-1:0]  b_ff, b_in;
   logic [ID_BITS-1:0] xor_dist;
   logic [ID_BITS-1:0] row_valid_ff;
   logic               rsp_valid_ff;
   kbt_pkg::rsp_type   rsp_ff;

   logic               req_fire;
   logic               out_free;
   logic               commit;
   logic               ram_wr_en;
   logic [BIDX_W-1:0]  ram_rd_addr;
   logic [ROW_W-1:0]   row_rd;
   logic [ROW_W-1:0]   row_wr;
   kbt_pkg::rsp_type   upd_rsp;
   kbt_pkg::ctl_type   upd_ctl;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == kbt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == kbt_pkg::ST_EXEC) && out_free;
   assign ram_wr_en  = commit && upd_ctl.wr_en;

   // bucket of the item: verdicts work on the pending peer
   always_comb begin
      op_in.action     = req_tuser;
      op_in.alive      = req_tdata[AL_BIT];
      op_in.pend_valid = pend_valid_ff;
      op_in.no_pending = (req_tuser == kbt_pkg::ACT_VERDICT) && !pend_valid_ff;
      if (req_tuser == kbt_pkg::ACT_VERDICT) begin
         id_in = pend_id_ff;
         ep_in = pend_ep_ff;
      end else begin
         id_in = req_tdata[ID_BITS-1:0];
         ep_in = req_tdata[EP_LSB +: EP_W];
      end
      xor_dist      = id_in ^ own_id_ff;
      op_in.own_hit = (xor_dist == '0);
      b_in          = '0;
      for (int i = 0; i < ID_BITS; i++) begin
         if (xor_dist[i]) begin
            b_in = BIDX_W'(i);
         end
      end
   end

   assign ram_rd_addr = (state_ff == kbt_pkg::ST_IDLE) ? b_in : b_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kbt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = kbt_pkg::ST_EXEC;
            end
         end
         kbt_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = kbt_pkg::ST_IDLE;
            end
         end
         default: state_in = kbt_pkg::ST_IDLE;
      endcase
   end

   kbt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ID_BITS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (b_ff),
      .wr_data (row_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (row_rd)
   );

   kbt_bucket_update #(
      .ID_BITS       (ID_BITS),
      .BUCKET_SLOTS  (BUCKET_SLOTS),
      .ENDPOINT_BITS (ENDPOINT_BITS)
   ) u_update (
      .op        (op_ff),
      .peer_id   (id_ff),
      .peer_ep   (ep_ff),
      .bucket    (b_ff),
      .row_valid (row_valid_ff[b_ff]),
      .row_rd    (row_rd),
      .row_wr    (row_wr),
      .rsp       (upd_rsp),
      .ctl       (upd_ctl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kbt_pkg::ST_IDLE;
         own_id_ff     <= '0;
         pend_valid_ff <= 1'b0;
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            own_id_ff <= csr_data[ID_BITS-1:0];
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            row_valid_ff[b_ff] <= 1'b1;
         end
         if (commit && upd_ctl.pend_set) begin
            pend_valid_ff <= 1'b1;
         end else if (commit && (op_ff.action == kbt_pkg::ACT_VERDICT)) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= op_in;
         id_ff <= id_in;
         ep_ff <= ep_in;
         b_ff  <= b_in;
      end
      if (commit) begin
         rsp_ff <= upd_rsp;
      end
      if (commit && upd_ctl.pend_set) begin
         pend_id_ff <= id_ff;
         pend_ep_ff <= ep_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.bucket_index, rsp_ff.result_endpoint, rsp_ff.result_id};

   a_commit_shows_beat: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("decided item did not reach the output register");

   a_pend_set_free: assert property (@(posedge clock) disable iff (reset)
      (commit && upd_ctl.pend_set) |-> !pend_valid_ff)
      else $error("pending peer overwritten");

   a_ping_has_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == kbt_pkg::RS_PING)) |-> pend_valid_ff)
      else $error("ping request shown without a pending peer");

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == kbt_pkg::ST_EXEC) && !req_tready)
      else $error("accepted item did not enter its decide cycle");

endmodule
